/* rtl/core/cpse_pkg.sv */
// ----------------------------------------------------------------------------
// cpse_pkg
// shared widths, codes and helper types of the coth power series evaluator
// ----------------------------------------------------------------------------
package cpse_pkg;

    localparam int MAX_TERMS = 64;
    localparam int FRAC_BITS = 16;
    localparam int ACC_FRAC  = 24;
    localparam int X_W       = 21;
    localparam int EPS_W     = 16;
    localparam int OUT_W     = 34;
    localparam int MAG_W     = 48;
    localparam int ACC_W     = MAG_W + 1;
    localparam int NUM_W     = ACC_W + 1;
    localparam int UNIT_W    = 68;
    localparam int CNT_W     = 7;
    localparam int K_W       = $clog2(MAX_TERMS + 1);

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(X_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(UNIT_W);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [UNIT_W-1:0] OUT_MAX_U = UNIT_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic [UNIT_W-1:0] OUT_MIN_U = UNIT_W'({1'b1, {(OUT_W-1){1'b0}}});
    localparam logic [MAG_W-1:0]  MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0]  MAG_ONE   = MAG_W'(1) << ACC_FRAC;

    typedef enum logic [0:0] {
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVK,
        S_ACC,
        S_QSTART,
        S_QUO,
        S_CHECK,
        S_DONE
    } core_state_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] coth_value;
        logic                    domain_error;
        logic                    not_converged;
    } result_t;

    function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] hi;
        logic signed [NUM_W-1:0] lo;
        hi = NUM_W'({1'b0, {(ACC_W-1){1'b1}}});
        lo = -(NUM_W'(1) << (ACC_W-1));
        if (v > hi)
            return hi[ACC_W-1:0];
        else if (v < lo)
            return lo[ACC_W-1:0];
        else
            return v[ACC_W-1:0];
    endfunction

endpackage

/* rtl/core/coth_power_series_evaluator_top.sv */
// ----------------------------------------------------------------------------
// coth_power_series_evaluator_top
// coth(x) of a Q4.16 argument by power series, Q17.16 result
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each series term takes a shift-add multiply, a
// divide by the term index and a quotient divide, all on the one shared
// bit-serial unit, plus sequencer states, for up to 64 terms; a zero argument
// goes straight to a domain-error result. The input is not ready while an item
// is being worked on. A finished result sits in an output register and the
// next beat is taken as soon as that register is loaded. eps resets to 66.
// ----------------------------------------------------------------------------
module coth_power_series_evaluator_top
    import cpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // x_value[20:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // coth_value[33:0]
    output logic [1:0]  m_tuser,    // not_converged, domain_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [EPS_W-1:0] eps_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             core_idle;
    logic             core_valid;
    logic             core_ready;
    result_t          core_res;

    assign core_ready = !out_valid_reg || m_tready;
    assign s_tready   = core_idle;
    assign cfg_ready  = 1'b1;

    cpse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && core_idle),
        .x_in      (s_tdata[X_W-1:0]),
        .eps       (eps_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= EPS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                eps_reg <= cfg_data;
            if (core_valid && core_ready)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && core_ready)
            out_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.coth_value};
    assign m_tuser  = {out_reg.not_converged, out_reg.domain_error};

endmodule

/* rtl/core/cpse_unit.sv */
// ----------------------------------------------------------------------------
// cpse_unit
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
module cpse_unit
    import cpse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  unit_req_t         req,
    input  logic [UNIT_W-1:0] opa,
    input  logic [UNIT_W-1:0] opb,
    output logic [UNIT_W-1:0] res,
    output logic              done
);

    logic              busy_reg;
    logic              done_reg;
    unit_op_t          op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [UNIT_W-1:0] acc_reg;
    logic [UNIT_W-1:0] a_reg;
    logic [UNIT_W-1:0] b_reg;

    logic [UNIT_W-1:0] trial;
    logic              ge;

    assign trial = {acc_reg[UNIT_W-2:0], a_reg[UNIT_W-1]};
    assign ge    = (trial >= b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            acc_reg <= '0;
            a_reg   <= opa;
            b_reg   <= opb;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                        acc_reg <= acc_reg + a_reg;
                    a_reg <= {a_reg[UNIT_W-2:0], 1'b0};
                    b_reg <= {1'b0, b_reg[UNIT_W-1:1]};
                end
                OP_DIV:
                begin
                    acc_reg <= ge ? (trial - b_reg) : trial;
                    a_reg   <= {a_reg[UNIT_W-2:0], ge};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign res  = (op_reg == OP_MUL) ? acc_reg : a_reg;
    assign done = done_reg;

endmodule

/* rtl/core/cpse_core.sv */
// ----------------------------------------------------------------------------
// cpse_core
// term sequencer: series accumulation, quotient and convergence test
// ----------------------------------------------------------------------------
module cpse_core
    import cpse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [X_W-1:0]   x_in,
    input  logic [EPS_W-1:0]        eps,
    output logic                    idle,
    output logic                    res_valid,
    input  logic                    res_ready,
    output result_t                 res
);

    core_state_t state_reg, state_next;

    logic                    xneg_reg, xneg_next;
    logic [X_W-1:0]          ax_reg, ax_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic signed [ACC_W-1:0] rev_reg, rev_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic signed [OUT_W-1:0] cur_reg, cur_next;
    logic signed [OUT_W-1:0] prev_reg, prev_next;
    logic                    neg_reg, neg_next;
    result_t                 res_reg, res_next;

    unit_req_t         req;
    logic [UNIT_W-1:0] opa;
    logic [UNIT_W-1:0] opb;
    logic [UNIT_W-1:0] ures;
    logic              udone;

    logic signed [NUM_W-1:0] t50;
    logic signed [NUM_W-1:0] tp;
    logic signed [NUM_W-1:0] tr;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
    logic [NUM_W-1:0]        num_abs;
    logic [NUM_W-1:0]        den_abs;
    logic signed [OUT_W:0]   diff;
    logic [OUT_W:0]          diff_abs;
    logic                    conv;

    cpse_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .res   (ures),
        .done  (udone)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        xneg_reg <= xneg_next;
        ax_reg   <= ax_next;
        mag_reg  <= mag_next;
        sum_reg  <= sum_next;
        rev_reg  <= rev_next;
        k_reg    <= k_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign t50      = NUM_W'(mag_reg);
    assign tp       = k_reg[0] ? (xneg_reg ? -t50 : t50) : t50;
    assign tr       = k_reg[0] ? -tp : t50;
    assign num      = NUM_W'(sum_reg) + NUM_W'(rev_reg);
    assign den      = NUM_W'(sum_reg) - NUM_W'(rev_reg);
    assign num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_abs  = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
    assign diff     = (OUT_W+1)'(cur_reg) - (OUT_W+1)'(prev_reg);
    assign diff_abs = diff[OUT_W] ? (OUT_W+1)'(-diff) : (OUT_W+1)'(diff);
    assign conv     = (k_reg >= K_W'(2)) && (diff_abs < (OUT_W+1)'(eps));

    always_comb
    begin
        state_next = state_reg;
        xneg_next  = xneg_reg;
        ax_next    = ax_reg;
        mag_next   = mag_reg;
        sum_next   = sum_reg;
        rev_next   = rev_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        req.start  = 1'b0;
        req.op     = OP_MUL;
        opa        = UNIT_W'(mag_reg);
        opb        = UNIT_W'(ax_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (x_in == '0)
                    begin
                        res_next.coth_value    = '0;
                        res_next.domain_error  = 1'b1;
                        res_next.not_converged = 1'b0;
                        state_next             = S_DONE;
                    end
                    else
                    begin
                        xneg_next  = x_in[X_W-1];
                        ax_next    = x_in[X_W-1] ? X_W'(-x_in) : X_W'(x_in);
                        mag_next   = MAG_ONE;
                        sum_next   = ACC_W'(MAG_ONE);
                        rev_next   = ACC_W'(MAG_ONE);
                        k_next     = K_W'(1);
                        cur_next   = '0;
                        prev_next  = '0;
                        state_next = S_MUL;
                        req.start  = 1'b1;
                        opa        = UNIT_W'(MAG_ONE);
                        opb        = UNIT_W'(ax_next);
                    end
                end
            end
            S_MUL:
            begin
                if (udone)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    opa        = ures >> FRAC_BITS;
                    opb        = UNIT_W'(k_reg);
                    state_next = S_DIVK;
                end
            end
            S_DIVK:
            begin
                if (udone)
                begin
                    mag_next   = (ures > UNIT_W'(MAG_MAX)) ? MAG_MAX : ures[MAG_W-1:0];
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next   = clamp_acc(NUM_W'(sum_reg) + tp);
                rev_next   = clamp_acc(NUM_W'(rev_reg) + tr);
                state_next = S_QSTART;
            end
            S_QSTART:
            begin
                prev_next = cur_reg;
                if (den == '0)
                begin
                    cur_next   = num[NUM_W-1] ? OUT_MIN : OUT_MAX;
                    state_next = S_CHECK;
                end
                else
                begin
                    neg_next   = num[NUM_W-1] ^ den[NUM_W-1];
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    opa        = UNIT_W'(num_abs) << FRAC_BITS;
                    opb        = UNIT_W'(den_abs);
                    state_next = S_QUO;
                end
            end
            S_QUO:
            begin
                if (udone)
                begin
                    if (neg_reg)
                        cur_next = (ures > OUT_MIN_U) ? OUT_MIN : -ures[OUT_W-1:0];
                    else
                        cur_next = (ures > OUT_MAX_U) ? OUT_MAX : ures[OUT_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (conv || (k_reg == K_W'(MAX_TERMS)))
                begin
                    res_next.coth_value    = cur_reg;
                    res_next.domain_error  = 1'b0;
                    res_next.not_converged = !conv;
                    state_next             = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    req.start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

/* rtl/core/cpse_checker.sv */
// ----------------------------------------------------------------------------
// cpse_checker
// port-level checks of the coth power series evaluator
// ----------------------------------------------------------------------------
module cpse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // domain error carries a zero value and no convergence flag
    a_domain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 40'd0) && !m_tuser[1])
        else $error("domain error beat malformed");

    // input busy right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // upper padding of tdata stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:34] == 6'd0))
        else $error("tdata padding not zero");

endmodule

bind coth_power_series_evaluator_top cpse_checker u_cpse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
